// File: design/bec_pkg.sv
`default_nettype none

package bec_pkg;

  // Debounce history length and count wrap
  localparam int unsigned HISTORY_DEPTH_DEF = 12;
  localparam int unsigned COUNT_RANGE       = 1024;
  localparam int unsigned CNT_W             = $clog2(COUNT_RANGE);

  // Field widths
  localparam int unsigned KEY_W  = 8;
  localparam int unsigned ENC_W  = 4;
  localparam int unsigned STEP_W = 3;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned TMR_W  = 8;

  // Register reset values
  localparam logic [TMR_W-1:0] HOLD_TICKS_RST = 8'd16;
  localparam logic [TMR_W-1:0] GAP_TICKS_RST  = 8'd32;

  // Register indexes
  localparam logic REG_HOLD = 1'b0;
  localparam logic REG_GAP  = 1'b1;

  // Single-key press values and the mode bits they toggle
  localparam logic [KEY_W-1:0] KEY_BTN1  = 8'h01;
  localparam logic [KEY_W-1:0] KEY_BTN2  = 8'h02;
  localparam logic [KEY_W-1:0] KEY_BTN4  = 8'h04;
  localparam logic [KEY_W-1:0] MODE_BIT7 = 8'h80;
  localparam logic [KEY_W-1:0] MODE_BIT6 = 8'h40;
  localparam logic [KEY_W-1:0] MODE_BIT5 = 8'h20;

  // Modes that select a step
  localparam logic [KEY_W-1:0] MODE_STEP1 = 8'h00;
  localparam logic [KEY_W-1:0] MODE_STEP2 = 8'h40;
  localparam logic [KEY_W-1:0] MODE_STEP4 = 8'h20;
  localparam logic [KEY_W-1:0] MODE_STEP0 = 8'h60;

  localparam logic [STEP_W-1:0] STEP_ONE  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_TWO  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_FOUR = 3'd4;
  localparam logic [STEP_W-1:0] STEP_ZERO = 3'd0;

  // Detent phases of a knob
  localparam logic [1:0] PH_REST  = 2'd0;
  localparam logic [1:0] PH_CW    = 2'd1;
  localparam logic [1:0] PH_MID   = 2'd2;
  localparam logic [1:0] PH_CCW   = 2'd3;

  // Phase pin codes
  localparam logic [1:0] PINS_00 = 2'd0;
  localparam logic [1:0] PINS_01 = 2'd1;
  localparam logic [1:0] PINS_10 = 2'd2;
  localparam logic [1:0] PINS_11 = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] value;
  } press_t;

endpackage

`default_nettype wire

// File: design/bec_debounce.sv
`default_nettype none

module bec_debounce
  import bec_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic [KEY_W-1:0] pins_i,
  output logic      [KEY_W-1:0] keys_o
);

  // Earlier samples, newest first; the current sample completes the window.
  logic [KEY_W-1:0] hist_q [HISTORY_DEPTH-1];
  logic [KEY_W-1:0] sample;

  assign sample = ~pins_i;

  always_comb begin
    keys_o = sample;
    for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
      keys_o = keys_o & hist_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        hist_q[i] <= '0;
      end
    end else if (adv_i) begin
      hist_q[0] <= sample;
      for (int i = 1; i < HISTORY_DEPTH - 1; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

endmodule

`default_nettype wire

// File: design/bec_press.sv
`default_nettype none

module bec_press
  import bec_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic [KEY_W-1:0]  keys_i,
  input  wire logic [TMR_W-1:0]  hold_ticks_i,
  input  wire logic [TMR_W-1:0]  gap_ticks_i,
  output press_t                 press_o,
  output logic      [KEY_W-1:0]  mode_o,
  output logic      [STEP_W-1:0] step_o,
  output logic      [STEP_W-1:0] step_old_o
);

  logic [TMR_W-1:0]  hold_q, hold_d;
  logic [TMR_W-1:0]  rel_q, rel_d;
  logic [KEY_W-1:0]  mode_q, mode_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    hold_d        = hold_q;
    rel_d         = rel_q;
    press_o.valid = 1'b0;
    press_o.value = '0;
    if (keys_i != '0) begin
      hold_d = (hold_q == '1) ? hold_q : hold_q + 1'b1;
      if (hold_d > hold_ticks_i && rel_q > gap_ticks_i) begin
        press_o.valid = 1'b1;
        press_o.value = keys_i;
        rel_d         = '0;
      end
    end else begin
      rel_d  = (rel_q == '1) ? rel_q : rel_q + 1'b1;
      hold_d = '0;
    end
  end

  always_comb begin
    mode_d = mode_q;
    step_d = step_q;
    if (press_o.valid) begin
      priority case (press_o.value)
        KEY_BTN1: mode_d = mode_q ^ MODE_BIT7;
        KEY_BTN2: mode_d = mode_q ^ MODE_BIT6;
        KEY_BTN4: mode_d = mode_q ^ MODE_BIT5;
        default:  mode_d = mode_q;
      endcase
      priority case (mode_d)
        MODE_STEP1: step_d = STEP_ONE;
        MODE_STEP2: step_d = STEP_TWO;
        MODE_STEP4: step_d = STEP_FOUR;
        MODE_STEP0: step_d = STEP_ZERO;
        default:    step_d = step_q;
      endcase
    end
  end

  assign mode_o     = mode_d;
  assign step_o     = step_d;
  assign step_old_o = step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
      rel_q  <= '0;
      mode_q <= '0;
      step_q <= STEP_ONE;
    end else if (adv_i) begin
      hold_q <= hold_d;
      rel_q  <= rel_d;
      mode_q <= mode_d;
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

// File: design/bec_knob.sv
`default_nettype none

module bec_knob
  import bec_pkg::*;
(
  input  wire logic [1:0]        phase_i,
  input  wire logic [1:0]        pins_i,
  input  wire logic [CNT_W-1:0]  count_i,
  input  wire logic [STEP_W-1:0] step_i,
  output logic      [1:0]        phase_o,
  output logic      [CNT_W-1:0]  count_o
);

  localparam logic [CNT_W:0] RANGE_X = (CNT_W+1)'(COUNT_RANGE);

  logic [CNT_W:0] cnt_x, st_x, up_sum, dn_sum;

  assign cnt_x  = {1'b0, count_i};
  assign st_x   = (CNT_W+1)'(step_i);
  assign up_sum = (cnt_x + st_x >= RANGE_X) ? cnt_x + st_x - RANGE_X : cnt_x + st_x;
  assign dn_sum = (cnt_x >= st_x) ? cnt_x - st_x : cnt_x + RANGE_X - st_x;

  always_comb begin
    phase_o = phase_i;
    count_o = count_i;
    unique case (phase_i)
      PH_REST: begin
        priority case (pins_i)
          PINS_01: phase_o = PH_CW;
          PINS_10: phase_o = PH_CCW;
          default: phase_o = PH_REST;
        endcase
      end
      PH_CW: begin
        priority case (pins_i)
          PINS_00: phase_o = PH_MID;
          PINS_11: begin
            phase_o = PH_MID;
            count_o = dn_sum[CNT_W-1:0];
          end
          default: phase_o = PH_CW;
        endcase
      end
      PH_MID: begin
        priority case (pins_i)
          PINS_10: phase_o = PH_CCW;
          PINS_01: phase_o = PH_CW;
          default: phase_o = PH_MID;
        endcase
      end
      PH_CCW: begin
        priority case (pins_i)
          PINS_11: begin
            phase_o = PH_REST;
            count_o = up_sum[CNT_W-1:0];
          end
          PINS_00: phase_o = PH_MID;
          default: phase_o = PH_CCW;
        endcase
      end
      default: phase_o = phase_i;
    endcase
  end

endmodule

`default_nettype wire

// File: design/button_encoder_tick_controller.sv
`default_nettype none

// Scan-tick controller for eight active-low pushbuttons and two quadrature
// knobs. Each input beat is one scan tick and yields exactly one output beat.
// A new tick is taken every clock cycle while the output side keeps up. A
// result is presented from the result register after its tick has passed
// the input register: the tick is held there, then the debounce, press and
// knob logic feed the result register. When the output stalls, the input
// register still takes one more tick before s_tready falls. The press hold
// and release gap thresholds sit at byte addresses 0x0 and 0x4 of the APB
// port and must only be written while no tick is in flight. A mode change
// made by a press sets the knob step from the following tick onwards.
module button_encoder_tick_controller
  import bec_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Tick input
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // switch_pins[7:0], encoder_bits[11:8], zero
  // Result output
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // debounced_keys[7:0], press_value[15:8],
                                      // mode_bits[23:16], step_size[26:24],
                                      // position_count[36:27], zero
  output logic      [0:0]  m_tuser    // press_valid[0]
);

  logic [TMR_W-1:0] hold_ticks_q, gap_ticks_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= HOLD_TICKS_RST;
      gap_ticks_q  <= GAP_TICKS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_HOLD: hold_ticks_q <= pwdata[TMR_W-1:0];
        REG_GAP:  gap_ticks_q  <= pwdata[TMR_W-1:0];
        default:  hold_ticks_q <= hold_ticks_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HOLD: prdata = 32'(hold_ticks_q);
      REG_GAP:  prdata = 32'(gap_ticks_q);
      default:  prdata = '0;
    endcase
  end

  // Input register
  logic             in_vld_q;
  logic [KEY_W-1:0] pins_q;
  logic [ENC_W-1:0] enc_q;
  logic             adv;

  assign adv      = in_vld_q && (!m_tvalid || m_tready);
  assign s_tready = !in_vld_q || !m_tvalid || m_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_tready) begin
      in_vld_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready && s_tvalid) begin
      pins_q <= s_tdata[KEY_W-1:0];
      enc_q  <= s_tdata[KEY_W +: ENC_W];
    end
  end

  // Per-tick logic
  logic [KEY_W-1:0]  keys;
  press_t            press;
  logic [KEY_W-1:0]  mode;
  logic [STEP_W-1:0] step_new, step_old;

  bec_debounce #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_debounce (
    .clk_i,
    .rst_ni,
    .adv_i  (adv),
    .pins_i (pins_q),
    .keys_o (keys)
  );

  bec_press u_press (
    .clk_i,
    .rst_ni,
    .adv_i        (adv),
    .keys_i       (keys),
    .hold_ticks_i (hold_ticks_q),
    .gap_ticks_i  (gap_ticks_q),
    .press_o      (press),
    .mode_o       (mode),
    .step_o       (step_new),
    .step_old_o   (step_old)
  );

  logic [1:0]       ph1_q, ph1_d, ph2_q, ph2_d;
  logic [CNT_W-1:0] cnt_q, cnt_mid, cnt_d;

  // Knob one moves the count first, knob two continues from its result.
  bec_knob u_knob1 (
    .phase_i (ph1_q),
    .pins_i  (enc_q[3:2]),
    .count_i (cnt_q),
    .step_i  (step_old),
    .phase_o (ph1_d),
    .count_o (cnt_mid)
  );

  bec_knob u_knob2 (
    .phase_i (ph2_q),
    .pins_i  (enc_q[1:0]),
    .count_i (cnt_mid),
    .step_i  (step_old),
    .phase_o (ph2_d),
    .count_o (cnt_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph1_q <= PH_REST;
      ph2_q <= PH_REST;
      cnt_q <= '0;
    end else if (adv) begin
      ph1_q <= ph1_d;
      ph2_q <= ph2_d;
      cnt_q <= cnt_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_tdata <= {3'b000, POS_W'(cnt_d), step_new, mode, press.value, keys};
      m_tuser <= press.valid;
    end
  end

endmodule

`default_nettype wire

// File: design/bec_checker.sv
`default_nettype none

module bec_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  // A result held under backpressure must not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // An accepted press reports the debounced keys, which cannot be empty.
  a_press_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser[0] |-> m_tdata[15:8] == m_tdata[7:0] && m_tdata[7:0] != 8'h00)
    else $error("press value does not match debounced keys");

  // Without a press the press value is zero.
  a_no_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tuser[0] |-> m_tdata[15:8] == 8'h00)
    else $error("press value set without a press");

  // The step is one of 0, 1, 2 or 4.
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[26:24] == 3'd0 || m_tdata[26:24] == 3'd1 ||
                 m_tdata[26:24] == 3'd2 || m_tdata[26:24] == 3'd4)
    else $error("illegal step size");

endmodule

bind button_encoder_tick_controller bec_checker u_bec_checker (.*);

`default_nettype wire

// File: tb/bec_scan_checker.sv
module bec_scan_checker
  import bec_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic [31:0] prdata,
  input  wire logic        pready,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [15:0] s_tdata,   // switch_pins[7:0], encoder_bits[11:8], zero
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [39:0] m_tdata,   // debounced_keys[7:0], press_value[15:8],
                                      // mode_bits[23:16], step_size[26:24],
                                      // position_count[36:27], zero
  input  wire logic [0:0]  m_tuser,   // press_valid[0]
  output int               fail_count,
  output int               pending,
  output int               beats_checked,
  output int               presses_seen
);

  typedef struct packed {
    logic [KEY_W-1:0]  keys;
    logic              pressed;
    logic [KEY_W-1:0]  value;
    logic [KEY_W-1:0]  mode;
    logic [STEP_W-1:0] step;
    logic [POS_W-1:0]  pos;
  } scan_result_t;

  // Register copies, tracked from the writes seen on the configuration port.
  logic [TMR_W-1:0]  hold_limit;
  logic [TMR_W-1:0]  gap_limit;

  logic [KEY_W-1:0]  key_history [HISTORY_DEPTH_DEF];
  int unsigned       history_slot;
  logic [TMR_W-1:0]  hold_ticks;
  logic [TMR_W-1:0]  release_ticks;
  logic [KEY_W-1:0]  mode_now;
  logic [STEP_W-1:0] step_now;
  logic [1:0]        knob_one;
  logic [1:0]        knob_two;
  logic [POS_W-1:0]  pos_now;

  scan_result_t      scan_q [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
    fail_count++;
  endtask

  function automatic logic [1:0] turn_knob(input logic [1:0] phase, input logic [1:0] pins,
                                           input logic [STEP_W-1:0] step);
    logic [1:0] phase_out;
    phase_out = phase;
    case (phase)
      PH_REST: begin
        if (pins == PINS_01) phase_out = PH_CW;
        else if (pins == PINS_10) phase_out = PH_CCW;
      end
      PH_CW: begin
        if (pins == PINS_00) begin
          phase_out = PH_MID;
        end else if (pins == PINS_11) begin
          phase_out = PH_MID;
          pos_now = pos_now - POS_W'(step);
        end
      end
      PH_MID: begin
        if (pins == PINS_10) phase_out = PH_CCW;
        else if (pins == PINS_01) phase_out = PH_CW;
      end
      default: begin
        if (pins == PINS_11) begin
          phase_out = PH_REST;
          pos_now = pos_now + POS_W'(step);
        end else if (pins == PINS_00) begin
          phase_out = PH_MID;
        end
      end
    endcase
    return phase_out;
  endfunction

  function automatic scan_result_t predict_tick(input logic [KEY_W-1:0] pins,
                                                input logic [ENC_W-1:0] enc);
    scan_result_t      res;
    logic [STEP_W-1:0] prior_step;
    logic [KEY_W-1:0]  keys;
    prior_step = step_now;
    key_history[history_slot] = ~pins;
    history_slot = (history_slot == HISTORY_DEPTH_DEF - 1) ? 0 : history_slot + 1;
    keys = '1;
    foreach (key_history[i]) keys &= key_history[i];
    res = '0;
    res.keys = keys;
    if (keys != '0) begin
      if (hold_ticks != '1) hold_ticks++;
      if (hold_ticks > hold_limit && release_ticks > gap_limit) begin
        res.pressed = 1'b1;
        res.value = keys;
        release_ticks = '0;
      end
    end else begin
      if (release_ticks != '1) release_ticks++;
      hold_ticks = '0;
    end
    if (res.pressed) begin
      case (keys)
        KEY_BTN1: mode_now ^= MODE_BIT7;
        KEY_BTN2: mode_now ^= MODE_BIT6;
        KEY_BTN4: mode_now ^= MODE_BIT5;
        default: ;
      endcase
      case (mode_now)
        MODE_STEP1: step_now = STEP_ONE;
        MODE_STEP2: step_now = STEP_TWO;
        MODE_STEP4: step_now = STEP_FOUR;
        MODE_STEP0: step_now = STEP_ZERO;
        default: ;
      endcase
    end
    // The knobs still use the step from before this tick's press.
    knob_one = turn_knob(knob_one, enc[3:2], prior_step);
    knob_two = turn_knob(knob_two, enc[1:0], prior_step);
    res.mode = mode_now;
    res.step = step_now;
    res.pos = pos_now;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scan_result_t want;
    scan_result_t got;
    if (!rst_ni) begin
      hold_limit = HOLD_TICKS_RST;
      gap_limit = GAP_TICKS_RST;
      foreach (key_history[i]) key_history[i] = '0;
      history_slot = 0;
      hold_ticks = '0;
      release_ticks = '0;
      mode_now = '0;
      step_now = STEP_ONE;
      knob_one = PH_REST;
      knob_two = PH_REST;
      pos_now = '0;
      scan_q.delete();
      fail_count = 0;
      beats_checked = 0;
      presses_seen = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_HOLD) hold_limit = pwdata[TMR_W-1:0];
          else gap_limit = pwdata[TMR_W-1:0];
        end else if (prdata !== {24'd0, (paddr[2] == REG_HOLD) ? hold_limit : gap_limit}) begin
          report_mismatch("register read", prdata,
                          {24'd0, (paddr[2] == REG_HOLD) ? hold_limit : gap_limit});
        end
      end
      // A result leaves only after its tick is registered, so compare before predicting.
      if (m_tvalid && m_tready) begin
        got.keys = m_tdata[7:0];
        got.value = m_tdata[15:8];
        got.mode = m_tdata[23:16];
        got.step = m_tdata[26:24];
        got.pos = m_tdata[36:27];
        got.pressed = m_tuser[0];
        if (scan_q.size() == 0) begin
          report_mismatch("unexpected result beat", m_tdata[31:0], 32'd0);
        end else begin
          want = scan_q.pop_front();
          beats_checked++;
          if (got.keys !== want.keys) report_mismatch("debounced_keys", got.keys, want.keys);
          if (got.pressed !== want.pressed)
            report_mismatch("press_valid", got.pressed, want.pressed);
          if (got.value !== want.value) report_mismatch("press_value", got.value, want.value);
          if (got.mode !== want.mode) report_mismatch("mode_bits", got.mode, want.mode);
          if (got.step !== want.step) report_mismatch("step_size", got.step, want.step);
          if (got.pos !== want.pos) report_mismatch("position_count", got.pos, want.pos);
          if (want.pressed) presses_seen++;
        end
      end
      if (s_tvalid && s_tready) scan_q.push_back(predict_tick(s_tdata[7:0], s_tdata[11:8]));
    end
    pending = scan_q.size();
  end

endmodule

// File: tb/tb_button_encoder_tick_controller.sv
module tb_button_encoder_tick_controller;
  import bec_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // switch_pins[7:0], encoder_bits[11:8], zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // debounced_keys[7:0], press_value[15:8], mode_bits[23:16],
                               // step_size[26:24], position_count[36:27], zero
  logic [0:0]  m_tuser;        // press_valid[0]

  int fail_count;
  int pending;
  int beats_checked;
  int presses_seen;

  int          cycle_count = 0;
  int          ticks_sent = 0;
  int          phase_end = 0;
  int          settings_run = 1;
  bit          calm = 1'b0;
  int unsigned knob_one_idx = 0;
  int unsigned knob_two_idx = 0;
  logic [7:0]  hold_cfg = HOLD_TICKS_RST;
  logic [7:0]  gap_cfg = GAP_TICKS_RST;

  button_encoder_tick_controller uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  bec_scan_checker scan_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .beats_checked(beats_checked),
    .presses_seen (presses_seen)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 7);
  end

  // Quadrature codes in the order a knob turning one way walks through them.
  function automatic logic [1:0] knob_code(input int unsigned idx);
    case (idx % 4)
      0: return PINS_11;
      1: return PINS_01;
      2: return PINS_00;
      default: return PINS_10;
    endcase
  endfunction

  function automatic int unsigned walk_knob(input int unsigned idx);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return (idx + 1) % 4;
    if (roll < 75) return (idx + 3) % 4;
    if (roll < 92) return idx;
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [3:0] next_encoder();
    knob_one_idx = walk_knob(knob_one_idx);
    knob_two_idx = walk_knob(knob_two_idx);
    return {knob_code(knob_one_idx), knob_code(knob_two_idx)};
  endfunction

  task automatic send_tick(input logic [7:0] pins, input logic [3:0] enc);
    while (!calm && $urandom_range(0, 99) < 7) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, enc, pins};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    ticks_sent++;
  endtask

  // A release followed by a press. Most phases run past the current thresholds plus
  // the debounce depth; the rest are short, and any tick may bounce to random pins.
  task automatic press_burst();
    int unsigned rel_len;
    int unsigned hold_len;
    int unsigned pick;
    logic [7:0]  keys;
    rel_len = ($urandom_range(0, 99) < 80) ?
              HISTORY_DEPTH_DEF + gap_cfg + $urandom_range(1, 10) : $urandom_range(1, 20);
    hold_len = ($urandom_range(0, 99) < 80) ?
               HISTORY_DEPTH_DEF + hold_cfg + $urandom_range(1, 10) : $urandom_range(1, 20);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      case ($urandom_range(0, 2))
        0: keys = KEY_BTN1;
        1: keys = KEY_BTN2;
        default: keys = KEY_BTN4;
      endcase
    end else if (pick < 75) begin
      keys = 8'h01 << $urandom_range(0, 7);
    end else if (pick < 90) begin
      keys = 8'($urandom_range(1, 255));
    end else begin
      keys = '1;
    end
    repeat (rel_len)
      send_tick(($urandom_range(0, 99) < 5) ? 8'($urandom_range(0, 255)) : 8'hFF,
                next_encoder());
    repeat (hold_len)
      send_tick(($urandom_range(0, 99) < 5) ? 8'($urandom_range(0, 255)) : ~keys,
                next_encoder());
  endtask

  task automatic apb_access(input logic idx, input logic write, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Registers change only once every tick in flight has produced its result.
  task automatic apply_setting(input logic [7:0] hold_val, input logic [7:0] gap_val);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    apb_access(REG_HOLD, 1'b1, {24'd0, hold_val});
    apb_access(REG_GAP, 1'b1, {24'd0, gap_val});
    apb_access(REG_HOLD, 1'b0, '0);
    apb_access(REG_GAP, 1'b0, '0);
    hold_cfg = hold_val;
    gap_cfg = gap_val;
    settings_run++;
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Pin extremes against every encoder code, then both knobs turned each way.
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0: send_tick(8'hFF, 4'(i));
        1: send_tick(8'h00, 4'(i));
        2: send_tick(8'hAA, 4'(i));
        default: send_tick(8'h55, 4'(i));
      endcase
    end
    for (int j = 1; j <= 4; j++) send_tick(8'hFF, {knob_code(j), knob_code(4 - j)});
    for (int j = 3; j >= 0; j--) send_tick(8'hFF, {knob_code(j), knob_code(4 - j)});
    knob_one_idx = 0;
    knob_two_idx = 0;

    while (ticks_sent < 200) press_burst();
    apply_setting(8'd0, 8'd0);
    while (ticks_sent < 420) press_burst();
    // Thresholds at full scale: the saturated timers can never exceed them.
    apply_setting(8'd255, 8'd255);
    press_burst();
    calm = 1'b1;
    apply_setting(8'($urandom_range(1, 20)), 8'($urandom_range(1, 20)));
    phase_end = ticks_sent + 200;
    while (ticks_sent < phase_end) press_burst();
    calm = 1'b0;
    apply_setting(8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)));
    phase_end = ticks_sent + 150;
    while (ticks_sent < phase_end) press_burst();

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    $display("Summary: %0d scan ticks sent, %0d results checked, %0d presses accepted,",
             ticks_sent, beats_checked, presses_seen);
    $display("         across %0d threshold settings including both extremes.", settings_run);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
